// ===== design/iso_ts_pkg.sv =====
// ----------------------------------------------------------------------------
// iso_ts_pkg: shared types and constants of the ISO-8601 timestamp parser
// Sequencer states, field codes, character codes and calendar tables.
// ----------------------------------------------------------------------------
package iso_ts_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SECS,
        ST_FRAC,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef logic [3:0] field_t;

    localparam field_t FLD_YEAR   = 4'd0;
    localparam field_t FLD_MONTH  = 4'd1;
    localparam field_t FLD_DAY    = 4'd2;
    localparam field_t FLD_HOUR   = 4'd3;
    localparam field_t FLD_MINUTE = 4'd4;
    localparam field_t FLD_SECOND = 4'd5;
    localparam field_t FLD_FRAC   = 4'd6;
    localparam field_t FLD_END    = 4'd7;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [13:0] YEAR_MIN      = 14'd1970;
    localparam logic [13:0] YEAR_MAX      = 14'd2200;
    localparam logic [13:0] YEAR_CENT_A   = 14'd2100;
    localparam logic [13:0] YEAR_CENT_B   = 14'd2200;
    localparam logic [13:0] LEAP_BASE     = 14'd492;
    localparam logic [29:0] NS_PER_S      = 30'd1000000000;
    localparam logic [3:0]  FRAC_PLACES   = 4'd9;
    localparam logic [4:0]  MUL_TOP_BIT   = 5'd29;

    function automatic logic [8:0] days_before_month(input logic [3:0] mi);
        logic [8:0] r;
        unique case (mi)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] mi);
        logic [4:0] r;
        unique case (mi)
            4'd1:                    r = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] separator(input field_t f);
        logic [7:0] r;
        unique case (f)
            FLD_YEAR, FLD_MONTH: r = CH_DASH;
            FLD_DAY:             r = CH_T;
            default:             r = CH_COLON;
        endcase
        return r;
    endfunction

endpackage

// ===== design/iso8601_utc_timestamp_parser.sv =====
// ----------------------------------------------------------------------------
// iso8601_utc_timestamp_parser: ISO-8601 UTC string to epoch nanoseconds
// Takes a timestamp string one character per transaction on the slave
// channel (s_tdata = character, s_tlast = final character) and returns a
// verdict and the time since 1970-01-01T00:00:00Z on the master channel
// (m_tuser = ok, m_tdata = nanoseconds, zero when rejected).
// The last character starts a small sequencer: a range/day check, a
// seconds step, a loop that scales the fraction digits kept (0..9) to
// nine places, a shift-add multiply by 10^9 over one 63-bit adder and a
// step to load the output register. A rejected string goes from the
// check straight to the output load. s_tready stays low from the last
// character until the result is loaded into the output register. While
// a result waits on m_tready, the next string is taken character by
// character; after its last character the sequencer holds the new
// result, with s_tready low, until the output register drains. Reset
// empties the output register and returns the parser to the start of a
// string.
// ----------------------------------------------------------------------------
module iso8601_utc_timestamp_parser #(
    parameter int FRACTION_DIGITS = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [62:0] epoch_ns, [63] zero
    output logic        m_tuser    // [0] ok
);

    iso_ts_pkg::state_t state_reg, state_next;
    iso_ts_pkg::field_t field_reg, field_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [29:0] frac_reg, frac_next;
    logic [3:0]  fdig_reg, fdig_next;
    logic        err_reg, err_next;
    logic [16:0] days_reg, days_next;
    logic [32:0] secs_reg, secs_next;
    logic [62:0] acc_reg, acc_next;
    logic [4:0]  bit_reg, bit_next;
    logic        ok_reg, ok_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    logic        accept;
    logic        is_dig;
    logic [3:0]  dig;
    logic [2:0]  dlimit;
    logic        out_free;
    logic        leap;
    logic        in_range;
    logic        day_ok;
    logic        ok_v;
    logic [3:0]  mi;
    logic [6:0]  max_day;
    logic [7:0]  yr_off;
    logic [5:0]  leaps;
    logic [16:0] days_v;

    assign s_tready = (state_reg == iso_ts_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign is_dig = (s_tdata >= iso_ts_pkg::CH_ZERO) && (s_tdata <= iso_ts_pkg::CH_NINE);
    assign dig    = s_tdata[3:0];
    assign dlimit = (field_reg == iso_ts_pkg::FLD_YEAR) ? 3'd4 : 3'd2;

    assign mi   = 4'(month_reg - 7'd1);
    assign leap = (year_reg[1:0] == 2'b00) && (year_reg != iso_ts_pkg::YEAR_CENT_A)
                  && (year_reg != iso_ts_pkg::YEAR_CENT_B);
    assign in_range = !err_reg && (field_reg == iso_ts_pkg::FLD_END)
                      && (year_reg >= iso_ts_pkg::YEAR_MIN)
                      && (year_reg <= iso_ts_pkg::YEAR_MAX)
                      && (month_reg >= 7'd1) && (month_reg <= 7'd12)
                      && (hour_reg <= 7'd23) && (minute_reg <= 7'd59)
                      && (second_reg <= 7'd60);
    assign max_day = {2'b00, iso_ts_pkg::month_length(mi)}
                     + {6'd0, (month_reg == 7'd2) && leap};
    assign day_ok  = (day_reg >= 7'd1) && (day_reg <= max_day);
    assign ok_v    = in_range && day_ok;

    assign yr_off = 8'(year_reg - iso_ts_pkg::YEAR_MIN);
    assign leaps  = 6'(((year_reg - 14'd1) >> 2) - iso_ts_pkg::LEAP_BASE
                       - {13'd0, year_reg > iso_ts_pkg::YEAR_CENT_A});
    assign days_v = 17'(17'd365 * {9'd0, yr_off}) + {11'd0, leaps}
                    + {8'd0, iso_ts_pkg::days_before_month(mi)}
                    + {16'd0, (month_reg > 7'd2) && leap}
                    + {10'd0, 7'(day_reg - 7'd1)};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iso_ts_pkg::ST_IDLE:
            begin
                if (accept && s_tlast)
                begin
                    state_next = iso_ts_pkg::ST_CHECK;
                end
            end
            iso_ts_pkg::ST_CHECK:
            begin
                state_next = ok_v ? iso_ts_pkg::ST_SECS : iso_ts_pkg::ST_DONE;
            end
            iso_ts_pkg::ST_SECS:
            begin
                state_next = iso_ts_pkg::ST_FRAC;
            end
            iso_ts_pkg::ST_FRAC:
            begin
                if (fdig_reg >= iso_ts_pkg::FRAC_PLACES)
                begin
                    state_next = iso_ts_pkg::ST_MUL;
                end
            end
            iso_ts_pkg::ST_MUL:
            begin
                if (bit_reg == 5'd0)
                begin
                    state_next = iso_ts_pkg::ST_DONE;
                end
            end
            iso_ts_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = iso_ts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iso_ts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        field_next    = field_reg;
        dcnt_next     = dcnt_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        frac_next     = frac_reg;
        fdig_next     = fdig_reg;
        err_next      = err_reg;
        days_next     = days_reg;
        secs_next     = secs_reg;
        acc_next      = acc_reg;
        bit_next      = bit_reg;
        ok_next       = ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            iso_ts_pkg::ST_IDLE:
            begin
                if (accept && !err_reg)
                begin
                    if (field_reg <= iso_ts_pkg::FLD_SECOND)
                    begin
                        if (is_dig)
                        begin
                            if (dcnt_reg >= dlimit)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                dcnt_next = 3'(dcnt_reg + 3'd1);
                                unique case (field_reg)
                                    iso_ts_pkg::FLD_YEAR:
                                        year_next = 14'(year_reg * 14'd10 + {10'd0, dig});
                                    iso_ts_pkg::FLD_MONTH:
                                        month_next = 7'(month_reg * 7'd10 + {3'd0, dig});
                                    iso_ts_pkg::FLD_DAY:
                                        day_next = 7'(day_reg * 7'd10 + {3'd0, dig});
                                    iso_ts_pkg::FLD_HOUR:
                                        hour_next = 7'(hour_reg * 7'd10 + {3'd0, dig});
                                    iso_ts_pkg::FLD_MINUTE:
                                        minute_next = 7'(minute_reg * 7'd10 + {3'd0, dig});
                                    default:
                                        second_next = 7'(second_reg * 7'd10 + {3'd0, dig});
                                endcase
                            end
                        end
                        else if (dcnt_reg == 3'd0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            dcnt_next = 3'd0;
                            if (field_reg < iso_ts_pkg::FLD_SECOND)
                            begin
                                if (s_tdata == iso_ts_pkg::separator(field_reg))
                                begin
                                    field_next = 4'(field_reg + 4'd1);
                                end
                                else
                                begin
                                    err_next = 1'b1;
                                end
                            end
                            else if (s_tdata == iso_ts_pkg::CH_DOT)
                            begin
                                field_next = iso_ts_pkg::FLD_FRAC;
                            end
                            else if (s_tdata == iso_ts_pkg::CH_Z)
                            begin
                                field_next = iso_ts_pkg::FLD_END;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                    end
                    else if (field_reg == iso_ts_pkg::FLD_FRAC)
                    begin
                        if (is_dig)
                        begin
                            if (fdig_reg < 4'(FRACTION_DIGITS))
                            begin
                                frac_next = 30'(frac_reg * 30'd10 + {26'd0, dig});
                                fdig_next = 4'(fdig_reg + 4'd1);
                            end
                            if (dcnt_reg < 3'd7)
                            begin
                                dcnt_next = 3'(dcnt_reg + 3'd1);
                            end
                        end
                        else if ((s_tdata == iso_ts_pkg::CH_Z) && (dcnt_reg != 3'd0))
                        begin
                            field_next = iso_ts_pkg::FLD_END;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            iso_ts_pkg::ST_CHECK:
            begin
                ok_next   = ok_v;
                days_next = days_v;
                acc_next  = 63'd0;
                if (!ok_v)
                begin
                    frac_next = 30'd0;
                end
            end
            iso_ts_pkg::ST_SECS:
            begin
                secs_next = 33'({16'd0, days_reg} * 33'd86400)
                            + 33'({26'd0, hour_reg} * 33'd3600)
                            + 33'({26'd0, minute_reg} * 33'd60)
                            + {26'd0, second_reg};
            end
            iso_ts_pkg::ST_FRAC:
            begin
                if (fdig_reg < iso_ts_pkg::FRAC_PLACES)
                begin
                    frac_next = 30'(frac_reg * 30'd10);
                    fdig_next = 4'(fdig_reg + 4'd1);
                end
                else
                begin
                    bit_next = iso_ts_pkg::MUL_TOP_BIT;
                end
            end
            iso_ts_pkg::ST_MUL:
            begin
                acc_next = {acc_reg[61:0], 1'b0}
                           + (iso_ts_pkg::NS_PER_S[bit_reg] ? {30'd0, secs_reg} : 63'd0);
                bit_next = 5'(bit_reg - 5'd1);
            end
            iso_ts_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, acc_reg + {33'd0, frac_reg}};
                    m_tuser_next  = ok_reg;
                    field_next    = iso_ts_pkg::FLD_YEAR;
                    dcnt_next     = 3'd0;
                    year_next     = 14'd0;
                    month_next    = 7'd0;
                    day_next      = 7'd0;
                    hour_next     = 7'd0;
                    minute_next   = 7'd0;
                    second_next   = 7'd0;
                    frac_next     = 30'd0;
                    fdig_next     = 4'd0;
                    err_next      = 1'b0;
                end
            end
            default:
            begin
                err_next = err_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= iso_ts_pkg::ST_IDLE;
            field_reg    <= iso_ts_pkg::FLD_YEAR;
            dcnt_reg     <= 3'd0;
            year_reg     <= 14'd0;
            month_reg    <= 7'd0;
            day_reg      <= 7'd0;
            hour_reg     <= 7'd0;
            minute_reg   <= 7'd0;
            second_reg   <= 7'd0;
            frac_reg     <= 30'd0;
            fdig_reg     <= 4'd0;
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            field_reg    <= field_next;
            dcnt_reg     <= dcnt_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            frac_reg     <= frac_next;
            fdig_reg     <= fdig_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg    <= days_next;
        secs_reg    <= secs_next;
        acc_reg     <= acc_next;
        bit_reg     <= bit_next;
        ok_reg      <= ok_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
